// File: rtl/tlaik_pkg.sv
// Shared types, widths and constants of the two-link arm inverse kinematics block.
`default_nettype none
package tlaik_pkg;

    localparam int POS_W      = 24;   // positions, mm Q.8
    localparam int LEN_W      = 23;   // link lengths, mm Q.8
    localparam int OP_W       = 25;   // multiplier operand
    localparam int PROD_W     = 50;   // multiplier product
    localparam int DEN_W      = 48;   // 2 * L1 * L2 and the divider remainder
    localparam int C_W        = 18;   // cos(q2), signed Q.16
    localparam int S_W        = 17;   // sin(q2), Q.16
    localparam int SQ_W       = 34;   // square root working width
    localparam int CW         = 48;   // CORDIC vector width
    localparam int ZW         = 21;   // CORDIC angle accumulator
    localparam int ANG_W      = 19;   // angle in [-pi, pi], Q.16
    localparam int Q1_W       = 20;
    localparam int Q2_W       = 18;
    localparam int D1_W       = 27;
    localparam int D2_W       = 25;
    localparam int STEP_W     = 5;
    localparam int ITER_CNT_W = 5;
    localparam int DATA_W     = 96;
    localparam int CFG_IDX_W  = 2;

    localparam logic signed [ZW-1:0] PI_Z      = ZW'(205887);
    localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(102944);
    localparam logic [21:0]          DEG_PER_RAD = 22'd3754937;
    localparam logic [D1_W-1:0]      DEG_LIM_ONE = D1_W'(35389440);
    localparam logic [D2_W-1:0]      DEG_LIM_TWO = D2_W'(11796480);
    localparam logic [C_W-1:0]       COS_ONE     = C_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINK_ONE = 2'd0,
        REG_LINK_TWO = 2'd1,
        REG_BASE_X   = 2'd2,
        REG_BASE_Y   = 2'd3
    } cfg_reg_e;

    typedef struct packed {
        logic signed [Q1_W-1:0] q1;
        logic [Q2_W-1:0]        q2;
        logic                   err;
    } lane_res_t;

    typedef struct packed {
        logic idle;
        logic done;
    } lane_stat_t;

    // atan(2^-i) in rad Q.16
    function automatic logic [15:0] atan_entry(input logic [ITER_CNT_W-1:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30386;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/two_link_arm_inverse_kinematics_top.sv
// Each lane runs a sequencer: multiply steps, 17 divide steps, 17 square root steps and three
// CORDIC passes, each of normalising shifts plus CORDIC_ITERATIONS rotations. The next
// transaction waits in the input register while the lanes work, and a result still held
// on m_tdata keeps the lanes from handing over.
// Reset (aresetn, synchronous, active low) empties all stages and loads the register defaults.
`default_nettype none
module two_link_arm_inverse_kinematics_top
    import tlaik_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 18
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // current_x, current_y, target_x, target_y (24 bits each)
    input  wire logic [DATA_W-1:0]     s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // target_joint_one_rad 20, target_joint_two_rad 18, delta_joint_one_deg 27,
    // delta_joint_two_deg 25, current_unreachable 1, target_unreachable 1, zero pad 4
    output logic [DATA_W-1:0]          m_tdata,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [POS_W-1:0]      cfg_wdata
);

    logic [LEN_W-1:0]         l1_reg, l2_reg;
    logic signed [POS_W-1:0]  offx_reg, offy_reg;
    logic                     pend_valid_reg;
    logic [DATA_W-1:0]        pend_data_reg;
    logic                     m_valid_reg;
    logic [DATA_W-1:0]        m_data_reg;
    logic signed [Q1_W-1:0]   q1_hold_reg;
    logic [Q2_W-1:0]          q2_hold_reg;
    logic                     cu_hold_reg, tu_hold_reg;

    lane_stat_t               stat_c, stat_t;
    lane_res_t                res_c, res_t;
    logic                     lanes_start, fire;
    logic                     merge_busy, merge_out_valid;
    logic signed [D1_W-1:0]   d1;
    logic signed [D2_W-1:0]   d2;

    assign s_tready    = !pend_valid_reg;
    assign lanes_start = pend_valid_reg && stat_c.idle && stat_t.idle;
    assign fire        = stat_c.done && stat_t.done && !m_valid_reg && !merge_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1_reg         <= LEN_W'(25600);
            l2_reg         <= LEN_W'(25600);
            offx_reg       <= '0;
            offy_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_e'(cfg_index))
                    REG_LINK_ONE: l1_reg   <= cfg_wdata[LEN_W-1:0];
                    REG_LINK_TWO: l2_reg   <= cfg_wdata[LEN_W-1:0];
                    REG_BASE_X:   offx_reg <= cfg_wdata;
                    REG_BASE_Y:   offy_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                pend_valid_reg <= 1'b1;
            else if (lanes_start)
                pend_valid_reg <= 1'b0;
            if (merge_out_valid)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
        if (s_tvalid && s_tready)
            pend_data_reg <= s_tdata;
        if (fire) begin
            q1_hold_reg <= res_t.q1;
            q2_hold_reg <= res_t.q2;
            cu_hold_reg <= res_c.err;
            tu_hold_reg <= res_t.err;
        end
        if (merge_out_valid)
            m_data_reg <= {4'd0, tu_hold_reg, cu_hold_reg, d2, d1, q2_hold_reg, q1_hold_reg};
    end

    tlaik_lane #(
        .ITER (CORDIC_ITERATIONS)
    ) u_lane_cur (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lanes_start),
        .take    (fire),
        .px      (pend_data_reg[23:0]),
        .py      (pend_data_reg[47:24]),
        .offx    (offx_reg),
        .offy    (offy_reg),
        .l1      (l1_reg),
        .l2      (l2_reg),
        .stat    (stat_c),
        .res     (res_c)
    );

    tlaik_lane #(
        .ITER (CORDIC_ITERATIONS)
    ) u_lane_tgt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lanes_start),
        .take    (fire),
        .px      (pend_data_reg[71:48]),
        .py      (pend_data_reg[95:72]),
        .offx    (offx_reg),
        .offy    (offy_reg),
        .l1      (l1_reg),
        .l2      (l2_reg),
        .stat    (stat_t),
        .res     (res_t)
    );

    tlaik_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (fire),
        .q1t       (res_t.q1),
        .q1c       (res_c.q1),
        .q2t       (res_t.q2),
        .q2c       (res_c.q2),
        .busy      (merge_busy),
        .out_valid (merge_out_valid),
        .d1        (d1),
        .d2        (d2)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // A merged result must never overwrite one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        merge_out_valid |-> !m_valid_reg)
        else $error("merged result arrived while output register was full");

    a_lanes_freed: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> stat_c.idle && stat_t.idle)
        else $error("lanes not released after hand-over to merge");

    a_merge_started: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> merge_busy)
        else $error("merge stage did not take the lane results");

endmodule
`default_nettype wire

// File: rtl/tlaik_cordic.sv
// Vectoring CORDIC giving atan2(y, x) in rad Q.16, one rotation per cycle.
`default_nettype none
module tlaik_cordic
    import tlaik_pkg::*;
#(
    parameter int ITER = 18
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic signed [CW-1:0]   y_in,
    input  wire logic signed [CW-1:0]   x_in,
    output logic                        done,
    output logic signed [ANG_W-1:0]     z_out
);

    typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER} cstate_t;

    localparam logic signed [CW-1:0] LIM  = CW'(64'd1 << 38);
    localparam logic signed [CW-1:0] LIM4 = CW'(64'd1 << 34);

    cstate_t                  state_reg;
    logic signed [CW-1:0]     x_reg, y_reg;
    logic signed [ZW-1:0]     z_reg;
    logic [ITER_CNT_W-1:0]    i_reg;
    logic                     done_reg;
    logic signed [CW-1:0]     dx, dy;
    logic [ZW-1:0]            step_ang;

    function automatic logic in_lim(input logic signed [CW-1:0] v,
                                    input logic signed [CW-1:0] lim);
        return (v < lim) && (v > -lim);
    endfunction

    always_comb begin
        dx       = y_reg >>> i_reg;
        dy       = x_reg >>> i_reg;
        step_ang = ZW'(atan_entry(i_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                C_IDLE: begin
                    if (start) begin
                        if (y_in == '0) begin
                            z_reg    <= (x_in < 0) ? PI_Z : '0;
                            done_reg <= 1'b1;
                        end else begin
                            // Turn a left-half vector by a quarter turn first.
                            if (x_in < 0) begin
                                if (y_in > 0) begin
                                    x_reg <= y_in;
                                    y_reg <= -x_in;
                                    z_reg <= HALF_PI_Z;
                                end else begin
                                    x_reg <= -y_in;
                                    y_reg <= x_in;
                                    z_reg <= -HALF_PI_Z;
                                end
                            end else begin
                                x_reg <= x_in;
                                y_reg <= y_in;
                                z_reg <= '0;
                            end
                            state_reg <= C_NORM;
                        end
                    end
                end
                C_NORM: begin
                    if (in_lim(x_reg, LIM4) && in_lim(y_reg, LIM4)) begin
                        x_reg <= x_reg <<< 4;
                        y_reg <= y_reg <<< 4;
                    end else if (in_lim(x_reg, LIM) && in_lim(y_reg, LIM)) begin
                        x_reg <= x_reg <<< 1;
                        y_reg <= y_reg <<< 1;
                    end else begin
                        i_reg     <= '0;
                        state_reg <= C_ITER;
                    end
                end
                C_ITER: begin
                    if (y_reg >= 0) begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + step_ang;
                    end else begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - step_ang;
                    end
                    i_reg <= i_reg + 1'b1;
                    if (i_reg == ITER_CNT_W'(ITER - 1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= C_IDLE;
                    end
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign done  = done_reg;
    assign z_out = (z_reg > PI_Z) ? ANG_W'(PI_Z) :
                   (z_reg < -PI_Z) ? ANG_W'(-PI_Z) : ANG_W'(z_reg);

endmodule
`default_nettype wire

// File: rtl/tlaik_lane.sv
// Solver lane: one point to both joint angles through a multiplier and a CORDIC shared by
// its steps, a divider and a square root.
`default_nettype none
module tlaik_lane
    import tlaik_pkg::*;
#(
    parameter int ITER = 18
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic                     take,
    input  wire logic signed [POS_W-1:0]  px,
    input  wire logic signed [POS_W-1:0]  py,
    input  wire logic signed [POS_W-1:0]  offx,
    input  wire logic signed [POS_W-1:0]  offy,
    input  wire logic [LEN_W-1:0]         l1,
    input  wire logic [LEN_W-1:0]         l2,
    output lane_stat_t                    stat,
    output lane_res_t                     res
);

    typedef enum logic [3:0] {
        L_IDLE, L_MUL, L_DCHK, L_DIV, L_SQMUL, L_SQLD, L_SQRT,
        L_WA, L_WB, L_PM1, L_PM2, L_PADD, L_WC, L_DONE
    } lstate_t;

    lstate_t                  state_reg;
    logic signed [POS_W-1:0]  x_reg, y_reg;
    logic [STEP_W-1:0]        step_reg;
    logic signed [PROD_W-1:0] prod_reg, acc_reg;
    logic [DEN_W-1:0]         den_reg, rem_reg;
    logic [15:0]              quo_reg;
    logic                     neg_reg, err_reg;
    logic signed [C_W-1:0]    c_reg;
    logic [SQ_W-1:0]          v_reg, r_reg;
    logic [S_W-1:0]           s_reg;
    logic [Q2_W-1:0]          q2_reg;
    logic signed [ANG_W-1:0]  a1_reg;
    logic signed [Q1_W-1:0]   q1_reg;
    logic signed [CW-1:0]     ys_reg, cx_reg, cy_reg;
    logic                     cstart_reg;

    logic signed [OP_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0]        mag;
    logic [DEN_W:0]           rsh;
    logic                     ge;
    logic [S_W-1:0]           qfin;
    logic [SQ_W-1:0]          bsq, tsum, r_nx;
    logic                     cdone;
    logic signed [ANG_W-1:0]  cz;

    function automatic logic signed [POS_W-1:0] sat_sub(input logic signed [POS_W-1:0] a,
                                                        input logic signed [POS_W-1:0] b);
        logic signed [POS_W:0] d;
        d = (POS_W+1)'(a) - (POS_W+1)'(b);
        if (d[POS_W] != d[POS_W-1])
            return d[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        return d[POS_W-1:0];
    endfunction

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            L_MUL: begin
                case (step_reg)
                    5'd0:    begin mul_a = OP_W'(x_reg); mul_b = OP_W'(x_reg); end
                    5'd1:    begin mul_a = OP_W'(y_reg); mul_b = OP_W'(y_reg); end
                    5'd2:    begin mul_a = OP_W'(l1);    mul_b = OP_W'(l1);    end
                    5'd3:    begin mul_a = OP_W'(l2);    mul_b = OP_W'(l2);    end
                    default: begin mul_a = OP_W'(l1);    mul_b = OP_W'(l2);    end
                endcase
            end
            L_SQMUL: begin mul_a = OP_W'(c_reg); mul_b = OP_W'(c_reg); end
            L_PM1:   begin mul_a = OP_W'(l2);    mul_b = OP_W'(s_reg); end
            L_PM2:   begin mul_a = OP_W'(l2);    mul_b = OP_W'(c_reg); end
            default: begin mul_a = '0;           mul_b = '0;           end
        endcase
    end

    always_comb begin
        mag  = (acc_reg < 0) ? PROD_W'(-acc_reg) : PROD_W'(acc_reg);
        // The first quotient bit weighs one whole; after that the remainder doubles.
        rsh  = (step_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        ge   = rsh >= {1'b0, den_reg};
        qfin = {quo_reg, ge};
        bsq  = SQ_W'(1) << (6'd32 - {step_reg, 1'b0});
        tsum = r_reg + bsq;
        r_nx = (v_reg >= tsum) ? ((r_reg >> 1) + bsq) : (r_reg >> 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= L_IDLE;
            cstart_reg <= 1'b0;
        end else begin
            cstart_reg <= 1'b0;
            prod_reg   <= mul_a * mul_b;
            case (state_reg)
                L_IDLE: begin
                    if (start) begin
                        x_reg     <= sat_sub(px, offx);
                        y_reg     <= sat_sub(py, offy);
                        step_reg  <= '0;
                        state_reg <= L_MUL;
                    end
                end
                L_MUL: begin
                    case (step_reg)
                        5'd0:       acc_reg <= '0;
                        5'd1, 5'd2: acc_reg <= acc_reg + prod_reg;
                        5'd3, 5'd4: acc_reg <= acc_reg - prod_reg;
                        default:    den_reg <= {prod_reg[DEN_W-2:0], 1'b0};
                    endcase
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 5'd5)
                        state_reg <= L_DCHK;
                end
                L_DCHK: begin
                    neg_reg <= acc_reg < 0;
                    if (mag > PROD_W'(den_reg)) begin
                        err_reg   <= 1'b1;
                        c_reg     <= (acc_reg < 0) ? -C_W'(COS_ONE) : C_W'(COS_ONE);
                        state_reg <= L_SQMUL;
                    end else if (den_reg == '0) begin
                        err_reg   <= 1'b0;
                        c_reg     <= '0;
                        state_reg <= L_SQMUL;
                    end else begin
                        err_reg   <= 1'b0;
                        rem_reg   <= mag[DEN_W-1:0];
                        quo_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= L_DIV;
                    end
                end
                L_DIV: begin
                    rem_reg  <= ge ? DEN_W'(rsh - {1'b0, den_reg}) : rsh[DEN_W-1:0];
                    quo_reg  <= qfin[15:0];
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 5'd16) begin
                        c_reg     <= neg_reg ? -C_W'(qfin) : C_W'(qfin);
                        state_reg <= L_SQMUL;
                    end
                end
                L_SQMUL: state_reg <= L_SQLD;
                L_SQLD: begin
                    v_reg     <= (SQ_W'(1) << 32) - prod_reg[SQ_W-1:0];
                    r_reg     <= '0;
                    step_reg  <= '0;
                    state_reg <= L_SQRT;
                end
                L_SQRT: begin
                    if (v_reg >= tsum)
                        v_reg <= v_reg - tsum;
                    r_reg    <= r_nx;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 5'd16) begin
                        s_reg      <= S_W'(r_nx);
                        cy_reg     <= CW'(r_nx);
                        cx_reg     <= CW'(c_reg);
                        cstart_reg <= 1'b1;
                        state_reg  <= L_WA;
                    end
                end
                L_WA: begin
                    if (cdone) begin
                        q2_reg     <= (cz < 0) ? '0 : Q2_W'(cz);
                        cy_reg     <= CW'(y_reg);
                        cx_reg     <= CW'(x_reg);
                        cstart_reg <= 1'b1;
                        state_reg  <= L_WB;
                    end
                end
                L_WB: begin
                    if (cdone) begin
                        a1_reg    <= cz;
                        state_reg <= L_PM1;
                    end
                end
                L_PM1: state_reg <= L_PM2;
                L_PM2: begin
                    ys_reg    <= CW'(prod_reg);
                    state_reg <= L_PADD;
                end
                L_PADD: begin
                    cx_reg     <= CW'({l1, 16'd0}) + CW'(prod_reg);
                    cy_reg     <= ys_reg;
                    cstart_reg <= 1'b1;
                    state_reg  <= L_WC;
                end
                L_WC: begin
                    if (cdone) begin
                        q1_reg    <= Q1_W'(a1_reg) - Q1_W'(cz);
                        state_reg <= L_DONE;
                    end
                end
                L_DONE: begin
                    if (take)
                        state_reg <= L_IDLE;
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    tlaik_cordic #(
        .ITER (ITER)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cstart_reg),
        .y_in    (cy_reg),
        .x_in    (cx_reg),
        .done    (cdone),
        .z_out   (cz)
    );

    assign stat.idle = state_reg == L_IDLE;
    assign stat.done = state_reg == L_DONE;
    assign res.q1    = q1_reg;
    assign res.q2    = q2_reg;
    assign res.err   = err_reg;

endmodule
`default_nettype wire

// File: rtl/tlaik_merge.sv
// Merging stage: joint differences of the two lanes turned into degrees, three stages.
`default_nettype none
module tlaik_merge
    import tlaik_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic signed [Q1_W-1:0]  q1t,
    input  wire logic signed [Q1_W-1:0]  q1c,
    input  wire logic [Q2_W-1:0]         q2t,
    input  wire logic [Q2_W-1:0]         q2c,
    output logic                         busy,
    output logic                         out_valid,
    output logic signed [D1_W-1:0]       d1,
    output logic signed [D2_W-1:0]       d2
);

    localparam int M1_W = Q1_W;
    localparam int M2_W = Q2_W;
    localparam int P1_W = M1_W + 22;
    localparam int P2_W = M2_W + 22;

    logic                    v1_reg, v2_reg, out_valid_reg;
    logic [M1_W-1:0]         m1_reg;
    logic [M2_W-1:0]         m2_reg;
    logic                    sg1_reg, sg2_reg, sg1b_reg, sg2b_reg;
    logic [P1_W-1:0]         p1_reg;
    logic [P2_W-1:0]         p2_reg;
    logic signed [D1_W-1:0]  d1_reg;
    logic signed [D2_W-1:0]  d2_reg;

    logic signed [Q1_W:0]    diff1;
    logic signed [Q2_W:0]    diff2;
    logic [D1_W-1:0]         r1, r2;
    logic [D1_W-1:0]         c1;
    logic [D2_W-1:0]         c2;

    always_comb begin
        diff1 = (Q1_W+1)'(q1t) - (Q1_W+1)'(q1c);
        diff2 = $signed({1'b0, q2t}) - $signed({1'b0, q2c});
        // Round half away from zero on the magnitude, then limit it.
        r1 = D1_W'((p1_reg + P1_W'(32768)) >> 16);
        r2 = D1_W'((p2_reg + P2_W'(32768)) >> 16);
        c1 = (r1 > DEG_LIM_ONE) ? DEG_LIM_ONE : r1;
        c2 = (r2 > D1_W'(DEG_LIM_TWO)) ? DEG_LIM_TWO : D2_W'(r2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            v1_reg        <= start;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
        if (start) begin
            sg1_reg <= diff1 < 0;
            sg2_reg <= diff2 < 0;
            m1_reg  <= (diff1 < 0) ? M1_W'(-diff1) : M1_W'(diff1);
            m2_reg  <= (diff2 < 0) ? M2_W'(-diff2) : M2_W'(diff2);
        end
        if (v1_reg) begin
            p1_reg   <= P1_W'(m1_reg) * P1_W'(DEG_PER_RAD);
            p2_reg   <= P2_W'(m2_reg) * P2_W'(DEG_PER_RAD);
            sg1b_reg <= sg1_reg;
            sg2b_reg <= sg2_reg;
        end
        if (v2_reg) begin
            d1_reg <= sg1b_reg ? -c1 : c1;
            d2_reg <= sg2b_reg ? -c2 : c2;
        end
    end

    assign busy      = v1_reg | v2_reg | out_valid_reg;
    assign out_valid = out_valid_reg;
    assign d1        = d1_reg;
    assign d2        = d2_reg;

endmodule
`default_nettype wire

// File: bench/tb_two_link_arm_inverse_kinematics_top.sv
// Self-checking testbench for the two-link arm inverse kinematics block.
`timescale 1ns / 100ps
module tb_two_link_arm_inverse_kinematics_top;
    import tlaik_pkg::*;

    localparam int N_RANDOM     = 1200;
    localparam int SETTLE_LIMIT = 2000;

    typedef struct {
        logic signed [Q1_W-1:0] q1;
        logic [Q2_W-1:0]        q2;
        logic signed [D1_W-1:0] d1;
        logic signed [D2_W-1:0] d2;
        logic                   cur_err;
        logic                   tgt_err;
    } joint_sol_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    wire               s_tready;
    logic [DATA_W-1:0] s_tdata = '0;
    wire               m_tvalid;
    logic              m_tready = 1'b0;
    wire  [DATA_W-1:0] m_tdata;
    logic              cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_LINK_ONE;
    logic [POS_W-1:0]  cfg_wdata = '0;

    longint link_one, link_two, base_x, base_y;
    joint_sol_t expected_sols[$];
    int errors = 0;

    two_link_arm_inverse_kinematics_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #10 aclk = ~aclk;

    initial begin
        #200_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint atan_tab(int i);
        longint t[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2, 1};
        return i < 17 ? t[i] : 0;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, t, dx, dy;
        longint lim;
        z = 0;
        lim = 64'sd1 <<< 38;
        if (y == 0) return x < 0 ? 205887 : 0;
        if (x < 0) begin
            t = x;
            if (y > 0) begin
                x = y; y = -t; z = 102944;
            end else begin
                x = -y; y = t; z = -102944;
            end
        end
        while (x < lim && x > -lim && y < lim && y > -lim) begin
            x *= 2;
            y *= 2;
        end
        for (int i = 0; i < 18; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_tab(i);
            end else begin
                x -= dx; y += dy; z -= atan_tab(i);
            end
        end
        return clamp(z, -205887, 205887);
    endfunction

    // Solves one point in the arm frame; returns the reach flag.
    function automatic bit solve_arm(longint x, longint y, output longint q1,
                                     output longint q2);
        longint n, c, s;
        longint unsigned mag, d;
        bit err;
        err = 1'b0;
        n = x * x + y * y - link_one * link_one - link_two * link_two;
        mag = n < 0 ? -n : n;
        d = 2 * link_one * link_two;
        if (mag > d) begin
            err = 1'b1;
            c = n < 0 ? -65536 : 65536;
        end else if (d == 0) begin
            c = 0;
        end else begin
            c = (mag << 16) / d;
            if (n < 0) c = -c;
        end
        s = int_sqrt(64'd65536 * 65536 - c * c);
        q2 = clamp(vector_angle(s, c), 0, 205887);
        q1 = vector_angle(y, x) - vector_angle(link_two * s, link_one * 65536 + link_two * c);
        return err;
    endfunction

    function automatic longint to_degrees(longint r, longint lim);
        longint unsigned m;
        longint v;
        m = r < 0 ? -r : r;
        m = (m * 3754937 + 32768) >> 16;
        v = m;
        if (r < 0) v = -v;
        return clamp(v, -lim, lim);
    endfunction

    function automatic joint_sol_t predict_joints(logic [DATA_W-1:0] d);
        joint_sol_t sol;
        longint cx, cy, tx, ty, q1c, q2c, q1t, q2t;
        cx = clamp(longint'($signed(d[23:0])) - base_x, -8388608, 8388607);
        cy = clamp(longint'($signed(d[47:24])) - base_y, -8388608, 8388607);
        tx = clamp(longint'($signed(d[71:48])) - base_x, -8388608, 8388607);
        ty = clamp(longint'($signed(d[95:72])) - base_y, -8388608, 8388607);
        sol.cur_err = solve_arm(cx, cy, q1c, q2c);
        sol.tgt_err = solve_arm(tx, ty, q1t, q2t);
        sol.q1 = q1t[Q1_W-1:0];
        sol.q2 = q2t[Q2_W-1:0];
        sol.d1 = D1_W'(to_degrees(q1t - q1c, 540 * 65536));
        sol.d2 = D2_W'(to_degrees(q2t - q2c, 180 * 65536));
        return sol;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic write_reg(cfg_reg_e idx, logic [POS_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_LINK_ONE: link_one = val[22:0];
            REG_LINK_TWO: link_two = val[22:0];
            REG_BASE_X:   base_x = longint'($signed(val));
            REG_BASE_Y:   base_y = longint'($signed(val));
            default: ;
        endcase
    endtask

    // The valid line stays high after a transaction so that the next one can follow at once.
    task automatic send_points(logic [23:0] cx, logic [23:0] cy, logic [23:0] tx,
                               logic [23:0] ty);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ty, tx, cy, cx};
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        expected_sols.push_back(predict_joints({ty, tx, cy, cx}));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_sols.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic logic [23:0] reach_point();
        longint reach, a;
        real ang;
        reach = (link_one + link_two) * $urandom_range(0, 110) / 100;
        ang = $urandom_range(0, 6283) / 1000.0;
        a = longint'(reach * $cos(ang));
        return 24'(clamp(a, -8388608, 8388607));
    endfunction

    // Result checker with random back-pressure.
    initial begin
        joint_sol_t e;
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (m_tvalid !== 1'b1) @(posedge aclk);
            if (expected_sols.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                e = expected_sols.pop_front();
                if ($signed(m_tdata[19:0]) != e.q1)
                    report_mismatch("q1", $signed(m_tdata[19:0]), e.q1);
                if (m_tdata[37:20] != e.q2) report_mismatch("q2", m_tdata[37:20], e.q2);
                if ($signed(m_tdata[64:38]) != e.d1)
                    report_mismatch("d1", $signed(m_tdata[64:38]), e.d1);
                if ($signed(m_tdata[89:65]) != e.d2)
                    report_mismatch("d2", $signed(m_tdata[89:65]), e.d2);
                if (m_tdata[90] != e.cur_err) report_mismatch("cur_err", m_tdata[90], e.cur_err);
                if (m_tdata[91] != e.tgt_err) report_mismatch("tgt_err", m_tdata[91], e.tgt_err);
            end
        end
    end

    task automatic test_directed();
        send_points(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF);
        send_points(24'd0, 24'd0, 24'd0, 24'd0);                 // base origin
        send_points(24'(-10000), 24'd0, 24'(-20000), 24'd0);     // negative x axis
        send_points(24'd51200, 24'd0, 24'd0, 24'd51200);         // reach exactly at the limit
        send_points(24'd60000, 24'd3, 24'd100, 24'd100);
        send_points(24'hFFFFFF, 24'h000001, 24'd25600, 24'(-25600));
        wait_drained();
        write_reg(REG_LINK_ONE, 24'd0);                          // zero link length
        write_reg(REG_LINK_TWO, 24'd0);
        send_points(24'd0, 24'd0, 24'd5, 24'd7);
        wait_drained();
        write_reg(REG_LINK_ONE, 24'h7FFFFF);
        write_reg(REG_LINK_TWO, 24'd1);
        send_points(24'h7FFFFF, 24'd0, 24'h7FFFFF, 24'h7FFFFF);
        send_points(24'(-300), 24'd300, 24'd1, 24'd0);
        wait_drained();
        write_reg(REG_BASE_X, 24'h7FFFFF);
        write_reg(REG_BASE_Y, 24'h800000);
        send_points(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000);
        send_points(24'd0, 24'd0, 24'h123456, 24'hABCDEF);
        wait_drained();
    endtask

    task automatic test_random();
        logic [23:0] vals[4];
        for (int phase = 0; phase < 4; phase++) begin
            write_reg(REG_LINK_ONE, 24'($urandom_range(1, phase == 3 ? 8388607 : 60000)));
            write_reg(REG_LINK_TWO, 24'($urandom_range(1, phase == 3 ? 8388607 : 60000)));
            write_reg(REG_BASE_X, 24'($urandom_range(0, 40000)) - 24'd20000);
            write_reg(REG_BASE_Y, phase == 2 ? 24'h800000 : 24'd0);
            for (int i = 0; i < N_RANDOM / 4; i++) begin
                if ($urandom_range(0, 4) == 0) begin
                    foreach (vals[k]) vals[k] = 24'($urandom);
                end else begin
                    foreach (vals[k]) vals[k] = 24'(reach_point() + (k[0] ? base_y : base_x));
                end
                send_points(vals[0], vals[1], vals[2], vals[3]);
            end
            wait_drained();
        end
    endtask

    initial begin
        link_one = 25600;
        link_two = 25600;
        base_x = 0;
        base_y = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        repeat (SETTLE_LIMIT / 10) @(posedge aclk);
        if (errors == 0 && expected_sols.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
